// ----- hw/rtl/mtf_pkg.sv -----
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants for the move-to-front list.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 4;
    localparam int LEN_W  = 5;

    // Request kinds carried in tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Controls broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;     // register the key compare
        logic insert_en;  // shift every cell back by one place
        logic move_en;    // shift cells up to the first match
    } mtf_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_COMP = 3'b010,
        ST_UPD  = 3'b100
    } mtf_state_t;

endpackage

// ----- hw/rtl/mtf_cell.sv -----
// ----------------------------------------------------------------------------
// mtf_cell
// One list position: holds a word and its valid bit, compares against the
// key and takes the word of its front neighbor when told to shift.
// ----------------------------------------------------------------------------
module mtf_cell
    import mtf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mtf_ctrl_t         ctrl,
    input  logic [WORD_W-1:0] key,
    input  logic [WORD_W-1:0] prev_word,
    input  logic              prev_valid,
    input  logic              before_in,
    output logic [WORD_W-1:0] word,
    output logic              valid,
    output logic              match,
    output logic              before_out
);

    logic [WORD_W-1:0] word_reg;
    logic              valid_reg;
    logic              match_reg;
    logic              shift;

    // Shift on insert, or on a move when no match lies nearer the front
    assign shift = ctrl.insert_en | (ctrl.move_en & ~before_in);

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= prev_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.insert_en)
            begin
                valid_reg <= prev_valid;
            end
            if (ctrl.cmp_en)
            begin
                match_reg <= valid_reg & (word_reg == key);
            end
        end
    end

    assign word       = word_reg;
    assign valid      = valid_reg;
    assign match      = match_reg;
    assign before_out = before_in | match_reg;

endmodule

// ----- hw/rtl/move_to_front_list.sv -----
// ----------------------------------------------------------------------------
// move_to_front_list
// Self-organizing list of signed 32-bit words built as a row of cells.
// ----------------------------------------------------------------------------
// Sequence: accept the request, register the per-cell compare, then shift the
//   cell row and load the result once the output register can take it; a new
//   item is accepted only after the previous one has been applied.
// The next item is accepted while a result still waits in the output register.
// Reset: rst_n asynchronous, active low; clears the list to empty.
// ----------------------------------------------------------------------------
module move_to_front_list
    import mtf_pkg::*;
#(
    parameter int LIST_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [0] hit, [4:1] hit_position,
                                        // [9:5] list_length,
                                        // [41:10] front_word,
                                        // [42] insert_refused, [47:43] zero
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    // ------------------------------------------------------------------
    // Sequencer and request registers
    // ------------------------------------------------------------------
    mtf_state_t         state_reg, state_next;
    logic               req_reg;
    logic [WORD_W-1:0]  key_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Output register
    logic               out_valid_reg;
    logic               hit_out_reg;
    logic [POS_W-1:0]   pos_out_reg;
    logic [LEN_W-1:0]   len_out_reg;
    logic [WORD_W-1:0]  front_out_reg;
    logic               refused_out_reg;

    mtf_ctrl_t          ctrl;
    logic               in_take;
    logic               out_take;
    logic               apply;
    logic               full;
    logic               any_hit;
    logic [IDX_W-1:0]   first_pos;
    logic [31:0]        pos_wide;
    logic [31:0]        len_wide;
    logic [WORD_W-1:0]  front_next;

    // Cell row
    logic [WORD_W-1:0]  cell_word  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_valid;
    logic [LIST_DEPTH-1:0] cell_match;
    logic [LIST_DEPTH:0]   hit_ahead;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid & s_axis_tready;
    assign out_take      = out_valid_reg & m_axis_tready;

    // Apply the update once the output register can take the result
    assign apply = (state_reg == ST_UPD) & (~out_valid_reg | m_axis_tready);
    assign full  = (count_reg == CNT_W'(LIST_DEPTH));

    // First match nearest the front; later cells lose priority
    always_comb
    begin
        first_pos = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
        begin
            if (cell_match[i])
            begin
                first_pos = IDX_W'(i);
            end
        end
    end
    assign any_hit = hit_ahead[LIST_DEPTH];

    always_comb
    begin
        ctrl.cmp_en    = (state_reg == ST_COMP);
        ctrl.insert_en = apply & (req_reg == REQ_INSERT) & ~full;
        ctrl.move_en   = apply & (req_reg == REQ_SEARCH) & any_hit;
    end

    assign count_next = ctrl.insert_en ? count_reg + CNT_W'(1) : count_reg;

    // Front word after this request: zero if the list is empty, the key if it went to the front, else cell 0's word
    always_comb
    begin
        priority if (count_next == '0)
        begin
            front_next = '0;
        end
        else if (ctrl.insert_en | ctrl.move_en)
        begin
            front_next = key_reg;
        end
        else
        begin
            front_next = cell_word[0];
        end
    end

    // Mask position and length to their field widths
    assign pos_wide = (req_reg == REQ_SEARCH && any_hit) ? 32'(first_pos) : 32'd0;
    assign len_wide = 32'(count_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (apply)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (apply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture the request, hold the result
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg <= s_axis_tuser[0];
            key_reg <= s_axis_tdata;
        end
        if (apply)
        begin
            hit_out_reg     <= (req_reg == REQ_SEARCH) & any_hit;
            pos_out_reg     <= pos_wide[POS_W-1:0];
            len_out_reg     <= len_wide[LEN_W-1:0];
            front_out_reg   <= front_next;
            refused_out_reg <= (req_reg == REQ_INSERT) & full;
        end
    end

    // ------------------------------------------------------------------
    // Cell row: cell 0 takes the key, each later cell its front neighbor
    // ------------------------------------------------------------------
    assign hit_ahead[0] = 1'b0;

    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        logic [WORD_W-1:0] prev_word;
        logic              prev_valid;

        if (g == 0)
        begin : g_head
            assign prev_word  = key_reg;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_word  = cell_word[g-1];
            assign prev_valid = cell_valid[g-1];
        end

        mtf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key_reg),
            .prev_word  (prev_word),
            .prev_valid (prev_valid),
            .before_in  (hit_ahead[g]),
            .word       (cell_word[g]),
            .valid      (cell_valid[g]),
            .match      (cell_match[g]),
            .before_out (hit_ahead[g+1])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, refused_out_reg, front_out_reg, len_out_reg,
                            pos_out_reg, hit_out_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("word count exceeds list depth");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == 32'(count_reg))
        else $error("cell valid bits disagree with word count");

    a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (apply && req_reg == REQ_INSERT && full) |=> $stable(count_reg))
        else $error("refused insert changed the list length");

    a_refused_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(refused_out_reg && hit_out_reg))
        else $error("result flags both a hit and a refused insert");

endmodule
